### rtl/tksel_pkg.sv
// ----------------------------------------------------------------------------
// tksel_pkg
// Shared types and constants for the top-K largest selector.
// ----------------------------------------------------------------------------
package tksel_pkg;

  // Width of one Q16.16 sample
  localparam int unsigned SampleW = 32;
  // Width of the count register and of the keep limit
  localparam int unsigned CountW = 5;
  // Width of the rank output
  localparam int unsigned RankW = 4;
  // Most results one data set may emit
  localparam int unsigned ResultCap = 16;

  // Register map: word index of each register
  localparam logic RegTopCount = 1'b0;
  // Reset value of top_count
  localparam logic [CountW-1:0] TopCountRst = 5'd16;

  // Data passed between neighboring cells
  typedef struct packed {
    logic signed [SampleW-1:0] value;  // held value
    logic                      valid;  // entry held and inside the keep limit
    logic                      stay;   // entry >= incoming sample, keeps its place
  } link_t;

endpackage

### rtl/tksel_cfg_regs.sv
// ----------------------------------------------------------------------------
// tksel_cfg_regs
// APB-style register port holding the top_count register.
// ----------------------------------------------------------------------------
module tksel_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output logic [tksel_pkg::CountW-1:0]     top_count_o
);

  logic [tksel_pkg::CountW-1:0] top_count_d, top_count_q;
  logic                         wr_en;
  logic                         sel_top;

  assign pready  = 1'b1;
  assign sel_top = (paddr[2] == tksel_pkg::RegTopCount);
  assign wr_en   = psel && penable && pwrite && pready && sel_top;

  // register write
  always_comb begin
    top_count_d = top_count_q;
    if (wr_en) begin
      top_count_d = pwdata[tksel_pkg::CountW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_count_q <= tksel_pkg::TopCountRst;
    end else begin
      top_count_q <= top_count_d;
    end
  end

  // read back
  always_comb begin
    prdata = 32'd0;
    if (sel_top) begin
      prdata = {{(32 - tksel_pkg::CountW){1'b0}}, top_count_q};
    end
  end

  assign top_count_o = top_count_q;

endmodule

### rtl/tksel_cell.sv
// ----------------------------------------------------------------------------
// tksel_cell
// One slot of the sorted chain: keeps its value, takes the new sample or its
// upper neighbor's value on insert, and takes its lower neighbor on drain.
// ----------------------------------------------------------------------------
module tksel_cell (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  ins_i,       // insert a sample
  input  logic                                  shift_i,     // drain toward slot 0
  input  logic signed [tksel_pkg::SampleW-1:0]  sample_i,
  input  logic                                  in_limit_i,  // slot index below limit
  input  tksel_pkg::link_t                      prev_i,      // from the slot above
  input  tksel_pkg::link_t                      next_i,      // from the slot below
  output tksel_pkg::link_t                      link_o
);

  logic signed [tksel_pkg::SampleW-1:0] value_d, value_q;
  logic                                 valid_d, valid_q;
  logic                                 held;
  logic                                 stay;

  assign held = valid_q && in_limit_i;
  assign stay = held && (value_q >= sample_i);

  // next slot contents
  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    if (ins_i) begin
      if (!stay) begin
        value_d = prev_i.stay ? sample_i : prev_i.value;
      end
      valid_d = in_limit_i && (stay || prev_i.valid);
    end else if (shift_i) begin
      value_d = next_i.value;
      valid_d = next_i.valid;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign link_o.value = value_q;
  assign link_o.valid = held;
  assign link_o.stay  = stay;

endmodule

### rtl/top_k_largest_selector_unit.sv
// ----------------------------------------------------------------------------
// top_k_largest_selector_unit
// Keeps the largest top_count Q16.16 samples of a data set in a sorted chain
// of cells and emits them from largest down on the set's last sample.
// ----------------------------------------------------------------------------
// A sample is taken on any cycle with start high and busy low, and is sorted
// into the chain in that cycle, so samples without set_end go in at one per
// clock. A sample with set_end is sorted in likewise, then busy rises and the
// n kept values (1 <= n <= limit) leave through slot 0 at one per cycle, each
// shown for one cycle with result_strobe_o. The receiver cannot stall
// results. Equal values are kept within the limit, a later one below the
// earlier. top_count 0 acts as 1; values above MAX_KEPT or 16 are clamped.
// top_count must be written only while busy is low; the block does not
// enforce it.
// ----------------------------------------------------------------------------
module top_k_largest_selector_unit #(
  parameter int unsigned MAX_KEPT = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // sample channel
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [tksel_pkg::SampleW-1:0]  sample_value_i,
  input  logic                                  set_end_i,
  // result channel
  output logic                                  result_strobe_o,
  output logic signed [tksel_pkg::SampleW-1:0]  ranked_value_o,
  output logic [tksel_pkg::RankW-1:0]           rank_index_o,
  output logic                                  final_flag_o,
  // configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [2:0]                            paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  localparam int unsigned CapKept =
    (MAX_KEPT < tksel_pkg::ResultCap) ? MAX_KEPT : tksel_pkg::ResultCap;
  localparam logic [tksel_pkg::CountW-1:0] CapCount = tksel_pkg::CountW'(CapKept);

  logic [tksel_pkg::CountW-1:0] top_count;
  logic [tksel_pkg::CountW-1:0] limit;
  logic [MAX_KEPT-1:0]          in_limit;
  logic                         accept;
  logic                         emitting_d, emitting_q;
  logic [tksel_pkg::RankW-1:0]  rank_d, rank_q;
  logic                         last_beat;

  tksel_pkg::link_t lnk  [MAX_KEPT];
  tksel_pkg::link_t prv  [MAX_KEPT];
  tksel_pkg::link_t nxt  [MAX_KEPT];
  tksel_pkg::link_t head;
  tksel_pkg::link_t tail;

  // configuration register
  tksel_cfg_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .top_count_o (top_count)
  );

  // clamped keep limit
  always_comb begin
    if (top_count == '0) begin
      limit = tksel_pkg::CountW'(1);
    end else if (top_count > CapCount) begin
      limit = CapCount;
    end else begin
      limit = top_count;
    end
  end

  assign accept = start && !busy;

  // chain ends: slot 0 always takes the sample when it moves
  assign head = '{value: '0, valid: 1'b1, stay: 1'b1};
  assign tail = '{value: '0, valid: 1'b0, stay: 1'b0};

  // cell chain
  for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
    if (i < CapKept) begin : g_lim
      assign in_limit[i] = (tksel_pkg::CountW'(i) < limit);
    end else begin : g_nolim
      assign in_limit[i] = 1'b0;
    end

    if (i == 0) begin : g_head
      assign prv[i] = head;
    end else begin : g_mid
      assign prv[i] = lnk[i-1];
    end

    if (i == MAX_KEPT - 1) begin : g_tail
      assign nxt[i] = tail;
    end else begin : g_body
      assign nxt[i] = lnk[i+1];
    end

    tksel_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ins_i      (accept),
      .shift_i    (emitting_q),
      .sample_i   (sample_value_i),
      .in_limit_i (in_limit[i]),
      .prev_i     (prv[i]),
      .next_i     (nxt[i]),
      .link_o     (lnk[i])
    );
  end

  // drain control
  assign last_beat = emitting_q && !nxt[0].valid;

  always_comb begin
    emitting_d = emitting_q;
    rank_d     = rank_q;
    if (accept && set_end_i) begin
      emitting_d = 1'b1;
      rank_d     = '0;
    end else if (emitting_q) begin
      rank_d = rank_q + tksel_pkg::RankW'(1);
      if (last_beat) begin
        emitting_d = 1'b0;
        rank_d     = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emitting_q <= 1'b0;
      rank_q     <= '0;
    end else begin
      emitting_q <= emitting_d;
      rank_q     <= rank_d;
    end
  end

  // result beat from slot 0
  assign busy            = emitting_q;
  assign result_strobe_o = emitting_q;
  assign ranked_value_o  = lnk[0].value;
  assign rank_index_o    = rank_q;
  assign final_flag_o    = last_beat;

  // checks
  a_head_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emitting_q |-> lnk[0].valid)
    else $error("draining with an empty head slot");

  a_end_starts_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && set_end_i |=> result_strobe_o && rank_index_o == '0)
    else $error("set end did not start a result run");

  a_rank_steps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && !final_flag_o |=>
      result_strobe_o && rank_index_o == $past(rank_index_o) + tksel_pkg::RankW'(1))
    else $error("result run broke or rank skipped");

  a_final_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && final_flag_o |=> !busy && !lnk[0].valid)
    else $error("chain not empty after last result");

endmodule

### verif/top_k_largest_selector_unit_tb.sv
// ----------------------------------------------------------------------------
// top_k_largest_selector_unit_tb
// Self-checking bench for the top-K largest selector. A directed table covers
// the sample extremes, ties, a zero count, a count changed inside a data set
// and an oversized count; random data sets follow under a series of count
// settings. Every beat is checked against a sorted-list predictor or a table row.
// ----------------------------------------------------------------------------
module top_k_largest_selector_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned KeepMax      = 16;
  localparam int unsigned SampleTarget = 310;
  localparam int unsigned StallLimit   = 1000;
  localparam logic [2:0]  TopCountAddr = {tksel_pkg::RegTopCount, 2'b00};
  localparam logic signed [tksel_pkg::SampleW-1:0] QMax = 32'sh7FFF_FFFF;
  localparam logic signed [tksel_pkg::SampleW-1:0] QMin = 32'sh8000_0000;

  // one result beat as the block emits it
  typedef struct packed {
    logic signed [tksel_pkg::SampleW-1:0] value;
    logic [tksel_pkg::RankW-1:0]          rank;
    logic                                 final_flag;
  } rank_beat_t;

  // one row of the directed table; a count write goes before the sample
  typedef struct packed {
    logic                                 load_cnt;
    logic [tksel_pkg::CountW-1:0]         cnt;
    logic signed [tksel_pkg::SampleW-1:0] value;
    logic                                 set_end;
    logic                                 typed;
    rank_beat_t                           beat;
  } dir_row_t;

  localparam dir_row_t DirTable [19] = '{
    // single-sample sets at the extremes, answer is the sample itself
    '{1'b0, 5'd0,  QMax,             1'b1, 1'b1, '{QMax, 4'd0, 1'b1}},
    '{1'b0, 5'd0,  QMin,             1'b1, 1'b1, '{QMin, 4'd0, 1'b1}},
    '{1'b0, 5'd0,  32'sh0000_0000,   1'b1, 1'b1, '{32'sh0, 4'd0, 1'b1}},
    // ties and extremes mixed in one set
    '{1'b0, 5'd0,  32'sh0005_0000,   1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  32'shFFFD_0000,   1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  32'sh0005_0000,   1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  QMin,             1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  QMax,             1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  32'sh0005_0000,   1'b1, 1'b0, '0},
    // zero count keeps one
    '{1'b1, 5'd0,  32'sh0001_0000,   1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  32'sh0002_0000,   1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  QMin,             1'b1, 1'b0, '0},
    // count shrunk inside a set
    '{1'b1, 5'd3,  32'sh000A_0000,   1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  32'sh001E_0000,   1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  32'sh0014_0000,   1'b0, 1'b0, '0},
    '{1'b1, 5'd1,  32'sh0019_0000,   1'b1, 1'b0, '0},
    // oversized count
    '{1'b1, 5'd31, 32'shFFFF_FFFF,   1'b1, 1'b1, '{32'shFFFF_FFFF, 4'd0, 1'b1}},
    '{1'b0, 5'd0,  32'shFFFF_FFFF,   1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  32'sh0000_0001,   1'b1, 1'b0, '0}
  };

  localparam logic [tksel_pkg::CountW-1:0] EdgeCounts [5] =
    '{5'd0, 5'd31, 5'd1, 5'd16, 5'd17};

  logic                                 clk_i;
  logic                                 rst_ni;
  logic                                 start;
  logic                                 busy;
  logic signed [tksel_pkg::SampleW-1:0] sample_value_i;
  logic                                 set_end_i;
  logic                                 result_strobe_o;
  logic signed [tksel_pkg::SampleW-1:0] ranked_value_o;
  logic [tksel_pkg::RankW-1:0]          rank_index_o;
  logic                                 final_flag_o;
  logic                                 psel;
  logic                                 penable;
  logic                                 pwrite;
  logic [2:0]                           paddr;
  logic [31:0]                          pwdata;
  logic [31:0]                          prdata;
  logic                                 pready;

  // predictor state: current set's kept values, largest first
  logic signed [tksel_pkg::SampleW-1:0] kept_q [$];
  logic [tksel_pkg::CountW-1:0]         top_count_q;
  rank_beat_t                           ranked_q [$];
  int unsigned                          mismatch_cnt;
  int unsigned                          samples_sent;
  int unsigned                          stall_cycles;

  top_k_largest_selector_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .sample_value_i  (sample_value_i),
    .set_end_i       (set_end_i),
    .result_strobe_o (result_strobe_o),
    .ranked_value_o  (ranked_value_o),
    .rank_index_o    (rank_index_o),
    .final_flag_o    (final_flag_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    $display("mismatch @%0t: %s", $realtime, what);
    mismatch_cnt++;
  endtask

  // count after clamping: 0 acts as 1, never above the chain depth
  function automatic int unsigned keep_limit();
    int unsigned lim;
    lim = top_count_q;
    if (lim < 1) lim = 1;
    if (lim > KeepMax) lim = KeepMax;
    if (lim > tksel_pkg::ResultCap) lim = tksel_pkg::ResultCap;
    return lim;
  endfunction

  // sort one sample in; on set end queue the ranked run and clear the set
  function automatic void absorb_sample(input logic signed [tksel_pkg::SampleW-1:0] v,
                                        input logic e, input logic typed,
                                        input rank_beat_t typed_beat);
    int unsigned lim;
    int unsigned pos;
    rank_beat_t  b;
    lim = keep_limit();
    while (kept_q.size() > lim) void'(kept_q.pop_back());
    pos = 0;
    // later equal values go below the earlier ones
    while (pos < kept_q.size() && kept_q[pos] >= v) pos++;
    if (pos < lim) begin
      kept_q.insert(pos, v);
      if (kept_q.size() > lim) void'(kept_q.pop_back());
    end
    if (e) begin
      if (typed) begin
        ranked_q.push_back(typed_beat);
      end else begin
        foreach (kept_q[i]) begin
          b.value      = kept_q[i];
          b.rank       = tksel_pkg::RankW'(i);
          b.final_flag = (i == kept_q.size() - 1);
          ranked_q.push_back(b);
        end
      end
      kept_q.delete();
    end
  endfunction

  function automatic logic signed [tksel_pkg::SampleW-1:0] gen_value();
    logic signed [tksel_pkg::SampleW-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      // small integers, plenty of ties
      4, 5, 6: v = (tksel_pkg::SampleW'($urandom_range(0, 6)) - 3) << 16;
      7: begin
        case ($urandom_range(0, 3))
          0: v = QMax;
          1: v = QMin;
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: v = $signed($urandom) >>> $urandom_range(0, 24);
    endcase
    return v;
  endfunction

  // one APB transfer to the count register
  task automatic apb_xfer(input logic wr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= TopCountAddr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // stop sending and wait until every queued beat has come out
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (ranked_q.size() != 0 || busy);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_top_count(input logic [tksel_pkg::CountW-1:0] cnt);
    logic [31:0] wd;
    logic [31:0] rd;
    wait_drained();
    wd = $urandom;
    wd[tksel_pkg::CountW-1:0] = cnt;
    apb_xfer(1'b1, wd, rd);
    top_count_q = cnt;
    @(posedge clk_i);
    apb_xfer(1'b0, '0, rd);
    if (rd[tksel_pkg::CountW-1:0] !== cnt)
      report_mismatch($sformatf("top_count read %0d, wrote %0d",
                                rd[tksel_pkg::CountW-1:0], cnt));
  endtask

  // offer one sample after a gap, hold it until taken
  task automatic send_sample(input logic signed [tksel_pkg::SampleW-1:0] v,
                             input logic e, input int unsigned gap, input logic typed,
                             input rank_beat_t typed_beat);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start          <= 1'b1;
    sample_value_i <= v;
    set_end_i      <= e;
    do @(posedge clk_i); while (busy);
    absorb_sample(v, e, typed, typed_beat);
    samples_sent++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    rank_beat_t want;
    if (rst_ni && result_strobe_o) begin
      if (ranked_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat value %0d rank %0d final %0b",
                                  ranked_value_o, rank_index_o, final_flag_o));
      end else begin
        want = ranked_q.pop_front();
        if (ranked_value_o !== want.value)
          report_mismatch($sformatf("ranked_value %0d, want %0d (rank %0d)",
                                    ranked_value_o, want.value, want.rank));
        if (rank_index_o !== want.rank)
          report_mismatch($sformatf("rank_index %0d, want %0d",
                                    rank_index_o, want.rank));
        if (final_flag_o !== want.final_flag)
          report_mismatch($sformatf("final_flag %0b, want %0b (rank %0d)",
                                    final_flag_o, want.final_flag, want.rank));
      end
    end
  end

  // watchdog on cycles without any beat, result or register access
  always @(posedge clk_i) begin
    if ((start && !busy) || result_strobe_o || (psel && penable))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [31:0]                  rd;
    logic [tksel_pkg::CountW-1:0] cnt;
    int unsigned                  phase;
    int unsigned                  set_len;
    int unsigned                  cut;
    bit                           burst;
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    start          = 1'b0;
    sample_value_i = '0;
    set_end_i      = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    mismatch_cnt   = 0;
    samples_sent   = 0;
    top_count_q    = tksel_pkg::TopCountRst;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_xfer(1'b0, '0, rd);
    if (rd[tksel_pkg::CountW-1:0] !== tksel_pkg::TopCountRst)
      report_mismatch($sformatf("top_count after reset %0d",
                                rd[tksel_pkg::CountW-1:0]));
    @(posedge clk_i);

    // directed table
    for (int r = 0; r < $size(DirTable); r++) begin
      if (DirTable[r].load_cnt) set_top_count(DirTable[r].cnt);
      send_sample(DirTable[r].value, DirTable[r].set_end,
                  $urandom_range(0, 1) ? 0 : $urandom_range(1, 19),
                  DirTable[r].typed, DirTable[r].beat);
    end

    // random data sets, one count setting per phase (at times changed inside a set), edge counts first
    phase = 0;
    while (samples_sent < SampleTarget) begin
      cnt = (phase < 5) ? EdgeCounts[phase]
                        : tksel_pkg::CountW'($urandom_range(0, 31));
      set_top_count(cnt);
      burst = ($urandom_range(0, 2) == 0);
      for (int s = 0; s < 4; s++) begin
        // first set of a phase overfills the chain, later ones mostly short
        set_len = (s == 0 || $urandom_range(0, 5) == 0) ? $urandom_range(17, 22)
                                                        : $urandom_range(1, 8);
        cut = (set_len > 1 && $urandom_range(0, 7) == 0) ? $urandom_range(1, set_len - 1)
                                                         : 0;
        for (int k = 0; k < set_len; k++) begin
          if (cut != 0 && k == cut)
            set_top_count(tksel_pkg::CountW'($urandom_range(0, 31)));
          send_sample(gen_value(), k == set_len - 1,
                      burst ? 0 : $urandom_range(0, 19), 1'b0, '0);
        end
      end
      phase++;
    end

    wait_drained();
    repeat (16) @(posedge clk_i);
    if (ranked_q.size() != 0)
      report_mismatch($sformatf("%0d beats never arrived", ranked_q.size()));
    if (mismatch_cnt == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

### sim.f
rtl/tksel_pkg.sv
rtl/tksel_cfg_regs.sv
rtl/tksel_cell.sv
rtl/top_k_largest_selector_unit.sv
verif/top_k_largest_selector_unit_tb.sv
